>>> hw/rtl/pcpa_pkg.sv
// Shared constants and codes for the per-CPU page allocator.
package pcpa_pkg;

   localparam int PCPA_CPUS       = 8;
   localparam int PCPA_PAGES      = 32768;
   localparam int PCPA_PAGE_BYTES = 4096;

   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CPU_IN_W = 3;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic CSR_LOW_ADDR  = 1'b0;
   localparam logic CSR_HIGH_ADDR = 1'b1;

endpackage

>>> hw/rtl/per_cpu_page_allocator.sv
// Top level of the per-CPU page allocator: free lists, link memory and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_action, req_cpu, req_address
//   rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_page_address, rsp_source_cpu
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A free or a failed allocate loads the result register directly; a successful allocate first
// enters the pop state, where the registered next-link memory read gives the new list head.
// Reset empties every list through per-CPU head valid bits; no clearing pass runs.
// A result waiting on rsp_stall blocks the next request until it is taken.
// csr_ready is always high.
module per_cpu_page_allocator
   import pcpa_pkg::*;
#(
   parameter int CPUS       = PCPA_CPUS,
   parameter int PAGES      = PCPA_PAGES,
   parameter int PAGE_BYTES = PCPA_PAGE_BYTES
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [CPU_IN_W-1:0] req_cpu,
   input  logic [ADDR_W-1:0]   req_address,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_page_address,
   output logic [CPU_IN_W-1:0] rsp_source_cpu,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [ADDR_W-1:0]   csr_data
);

   localparam int CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int PG_W  = $clog2(PAGES);
   localparam int PB_W  = $clog2(PAGE_BYTES);
   localparam int CM_W  = CPU_W + 1;
   localparam logic [ADDR_W:0] PB_MASK    = (ADDR_W+1)'(PAGE_BYTES - 1);
   localparam logic [39:0]     PAGE_LIMIT = 40'(PAGES) << PB_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic                state_ff, state_in;
   logic [CPUS-1:0]     head_valid_ff, head_valid_in;
   logic [PG_W-1:0]     head_index_ff [CPUS];
   logic                head_we;
   logic [CPU_W-1:0]    head_waddr;
   logic [PG_W-1:0]     head_wdata;

   logic [ADDR_W-1:0]   low_addr_ff, high_addr_ff;

   logic [PG_W:0]       link_mem [PAGES];
   logic [PG_W:0]       link_rd_ff;
   logic                link_we, link_re;
   logic [PG_W-1:0]     link_waddr, link_raddr;
   logic [PG_W:0]       link_wdata;

   logic [CPU_W-1:0]    sel_ff, sel_in;
   logic [PG_W-1:0]     page_ff, page_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [CPU_IN_W-1:0] rsp_src_ff, rsp_src_in;
   logic                rsp_load;

   logic                accept;
   logic [CPU_W-1:0]    cpu_m;
   logic [CPU_W-1:0]    steal_cpu;
   logic                steal_found;
   logic [CPU_W-1:0]    head_raddr;
   logic [PG_W-1:0]     head_rd;
   logic [ADDR_W:0]     base;
   logic [39:0]         diff;
   logic                free_bad;
   logic [PG_W-1:0]     free_page;
   logic [ADDR_W-1:0]   pop_offset;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff == ST_POP) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_source_cpu   = rsp_src_ff;

   always_comb begin
      logic [3:0] v;
      v = 4'(req_cpu);
      for (int i = 0; i < 8; i++) begin
         if (v >= 4'(CPUS)) begin
            v = v - 4'(CPUS);
         end
      end
      cpu_m = CPU_W'(v);
   end

   always_comb begin
      logic [CM_W-1:0] idx;
      steal_found = 1'b0;
      steal_cpu   = '0;
      for (int k = 0; k < CPUS; k++) begin
         idx = CM_W'(cpu_m) + CM_W'(k);
         if (idx >= CM_W'(CPUS)) begin
            idx = idx - CM_W'(CPUS);
         end
         if (!steal_found && head_valid_ff[CPU_W'(idx)]) begin
            steal_found = 1'b1;
            steal_cpu   = CPU_W'(idx);
         end
      end
   end

   assign head_raddr = (req_action == ACTION_FREE) ? cpu_m : steal_cpu;
   assign head_rd    = head_index_ff[head_raddr];

   assign base      = ((ADDR_W+1)'(low_addr_ff) + PB_MASK) & ~PB_MASK;
   assign diff      = 40'(req_address) - 40'(base);
   assign free_page = diff[PB_W +: PG_W];
   assign free_bad  = (req_address[PB_W-1:0] != '0) || (req_address < low_addr_ff) ||
                      (req_address >= high_addr_ff) || (diff >= PAGE_LIMIT);

   assign pop_offset = ADDR_W'(page_ff) << PB_W;

   always_comb begin
      state_in      = state_ff;
      head_valid_in = head_valid_ff;
      head_we       = 1'b0;
      head_waddr    = cpu_m;
      head_wdata    = free_page;
      link_we       = 1'b0;
      link_re       = 1'b0;
      link_waddr    = free_page;
      link_wdata    = head_valid_ff[cpu_m] ? {1'b1, head_rd} : '0;
      link_raddr    = head_rd;
      sel_in        = sel_ff;
      page_in       = page_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_src_in    = rsp_src_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_FREE) begin
                  rsp_load    = 1'b1;
                  rsp_addr_in = '0;
                  rsp_src_in  = '0;
                  if (free_bad) begin
                     rsp_status_in = STATUS_BAD_FREE;
                  end else begin
                     rsp_status_in         = STATUS_OK;
                     link_we               = 1'b1;
                     head_we               = 1'b1;
                     head_valid_in[cpu_m]  = 1'b1;
                  end
               end else if (steal_found) begin
                  link_re  = 1'b1;
                  sel_in   = steal_cpu;
                  page_in  = head_rd;
                  state_in = ST_POP;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_NO_PAGE;
                  rsp_addr_in   = '0;
                  rsp_src_in    = '0;
               end
            end
         end
         ST_POP: begin
            rsp_load      = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_addr_in   = base[ADDR_W-1:0] + pop_offset;
            rsp_src_in    = CPU_IN_W'(sel_ff);
            head_waddr    = sel_ff;
            head_wdata    = link_rd_ff[PG_W-1:0];
            if (link_rd_ff[PG_W]) begin
               head_we = 1'b1;
            end else begin
               head_valid_in[sel_ff] = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         low_addr_ff   <= '0;
         high_addr_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LOW_ADDR:  low_addr_ff  <= csr_data;
               CSR_HIGH_ADDR: high_addr_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_src_ff    <= rsp_src_in;
      if (head_we) begin
         head_index_ff[head_waddr] <= head_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |=> state_ff == ST_IDLE)
      else $error("pop state held longer than one cycle");

   a_pop_rsp_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> !rsp_valid_ff)
      else $error("result register busy during pop");

   a_pop_list_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> head_valid_ff[sel_ff])
      else $error("pop from an empty list");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |->
         rsp_page_address == '0 && rsp_source_cpu == '0)
      else $error("error transaction carries a page");

endmodule

>>> bench/page_alloc_checker.sv
// Checker for the per-CPU page allocator: tracks free lists, predicts each result, compares.
`timescale 1ns / 1ps

module page_alloc_checker
   import pcpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_action,
   input  logic [CPU_IN_W-1:0] req_cpu,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [ADDR_W-1:0]   rsp_page_address,
   input  logic [CPU_IN_W-1:0] rsp_source_cpu,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic                csr_index,
   input  logic [ADDR_W-1:0]   csr_data,
   input  logic                end_of_run,
   output int                  outstanding,
   output int                  errors
);

   localparam int PAGE_IDX_W = $clog2(PCPA_PAGES);
   localparam logic [15:0] LINK_PRESENT = 16'h8000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page_address;
      logic [CPU_IN_W-1:0] source_cpu;
   } page_reply_type;

   page_reply_type         due_replies[$];
   page_reply_type         oldest;
   logic [ADDR_W-1:0]      low_bound;
   logic [ADDR_W-1:0]      high_bound;
   logic [PAGE_IDX_W-1:0]  list_head[PCPA_CPUS];
   bit                     list_filled[PCPA_CPUS];
   logic [15:0]            page_link[PCPA_PAGES];
   bit                     leftovers_checked;

   function automatic page_reply_type allocator_outcome(input logic action,
                                                        input logic [CPU_IN_W-1:0] cpu,
                                                        input logic [ADDR_W-1:0] address);
      page_reply_type        reply;
      longint unsigned       base;
      longint unsigned       addr64;
      longint unsigned       page;
      int unsigned           first;
      int unsigned           c;
      int unsigned           k;
      bit                    found;
      logic [PAGE_IDX_W-1:0] pg;
      reply  = '0;
      addr64 = 64'(address);
      base   = 64'(low_bound);
      base   = ((base + PCPA_PAGE_BYTES - 1) / PCPA_PAGE_BYTES) * PCPA_PAGE_BYTES;
      first  = cpu % PCPA_CPUS;
      if (action == ACTION_FREE) begin
         if ((addr64 % PCPA_PAGE_BYTES) != 0 || address < low_bound ||
             address >= high_bound) begin
            reply.status = STATUS_BAD_FREE;
         end else begin
            page = (addr64 - base) / PCPA_PAGE_BYTES;
            if (page >= PCPA_PAGES) begin
               reply.status = STATUS_BAD_FREE;
            end else begin
               pg = page[PAGE_IDX_W-1:0];
               page_link[pg]      = list_filled[first] ?
                                    (LINK_PRESENT | 16'(list_head[first])) : '0;
               list_head[first]   = pg;
               list_filled[first] = 1'b1;
               reply.status       = STATUS_OK;
            end
         end
      end else begin
         reply.status = STATUS_NO_PAGE;
         found = 1'b0;
         for (k = 0; k < PCPA_CPUS && !found; k++) begin
            c = (first + k) % PCPA_CPUS;
            if (list_filled[c]) begin
               found = 1'b1;
               pg = list_head[c];
               reply.status       = STATUS_OK;
               reply.page_address = 32'(base + longint'(pg) * PCPA_PAGE_BYTES);
               reply.source_cpu   = c[CPU_IN_W-1:0];
               if (page_link[pg] & LINK_PRESENT)
                  list_head[c] = page_link[pg][PAGE_IDX_W-1:0];
               else
                  list_filled[c] = 1'b0;
            end
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         due_replies.delete();
         errors     = 0;
         low_bound  = '0;
         high_bound = '0;
         for (int i = 0; i < PCPA_CPUS; i++) list_filled[i] = 1'b0;
         leftovers_checked = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOW_ADDR)
               low_bound = csr_data;
            else
               high_bound = csr_data;
         end
         if (req_valid && !req_stall)
            due_replies.push_back(allocator_outcome(req_action, req_cpu, req_address));
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $error("result with no transaction waiting: status %0d address %h cpu %0d",
                      rsp_status, rsp_page_address, rsp_source_cpu);
               errors++;
            end else begin
               oldest = due_replies.pop_front();
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  errors++;
               end
               if (rsp_page_address !== oldest.page_address) begin
                  $error("page_address: expected %h, got %h",
                         oldest.page_address, rsp_page_address);
                  errors++;
               end
               if (rsp_source_cpu !== oldest.source_cpu) begin
                  $error("source_cpu: expected %0d, got %0d",
                         oldest.source_cpu, rsp_source_cpu);
                  errors++;
               end
            end
         end
         if (end_of_run && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (due_replies.size() != 0) begin
               $error("%0d transactions never answered", due_replies.size());
               errors += due_replies.size();
            end
         end
      end
      outstanding = due_replies.size();
   end

endmodule

>>> bench/tb_per_cpu_page_allocator.sv
// Testbench top for the per-CPU page allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_per_cpu_page_allocator;
   import pcpa_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic                req_action  = ACTION_ALLOC;
   logic [CPU_IN_W-1:0] req_cpu     = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_page_address;
   logic [CPU_IN_W-1:0] rsp_source_cpu;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic                csr_index   = CSR_LOW_ADDR;
   logic [ADDR_W-1:0]   csr_data    = '0;
   logic                end_of_run  = 1'b0;
   int                  outstanding;
   int                  errors;

   logic [ADDR_W-1:0]   cur_low  = '0;
   logic [ADDR_W-1:0]   cur_high = '0;
   int                  burst_left   = 4;
   int                  stall_mode   = 0;
   int                  stall_left   = 0;
   int                  quiet_cycles = 0;

   per_cpu_page_allocator dut (.*);
   page_alloc_checker     scoreboard (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_left % 8) < 5);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic action, input logic [CPU_IN_W-1:0] cpu,
                            input logic [ADDR_W-1:0] address);
      req_valid   <= 1'b1;
      req_action  <= action;
      req_cpu     <= cpu;
      req_address <= address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_config(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] high);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_LOW_ADDR;
      csr_data  <= low;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_HIGH_ADDR;
      csr_data  <= high;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_low  = low;
      cur_high = high;
   endtask

   function automatic logic [ADDR_W-1:0] good_free_address();
      longint unsigned lo_page;
      longint unsigned hi_page;
      longint unsigned span;
      longint unsigned off;
      lo_page = 64'(cur_low);
      hi_page = 64'(cur_high);
      lo_page = (lo_page + PCPA_PAGE_BYTES - 1) / PCPA_PAGE_BYTES;
      hi_page = (hi_page + PCPA_PAGE_BYTES - 1) / PCPA_PAGE_BYTES;
      if (hi_page > lo_page + PCPA_PAGES) hi_page = lo_page + PCPA_PAGES;
      if (hi_page <= lo_page) return $urandom;
      span = hi_page - lo_page;
      if ($urandom_range(0, 1) == 0 && span > 32) span = 32;
      off = 64'($urandom_range(0, 32'(span - 1)));
      return 32'((lo_page + off) * PCPA_PAGE_BYTES);
   endfunction

   task automatic run_random(input int count, input int alloc_pct);
      int                  pick;
      logic                action;
      logic [ADDR_W-1:0]   address;
      for (int i = 0; i < count; i++) begin
         pick    = $urandom_range(0, 99);
         action  = ACTION_FREE;
         address = good_free_address();
         if (pick < alloc_pct) begin
            action  = ACTION_ALLOC;
            address = $urandom;
         end else if (pick >= 88) begin
            case ($urandom_range(0, 3))
               0: address = $urandom;
               1: address = address | $urandom_range(1, PCPA_PAGE_BYTES - 1);
               2: address = cur_high;
               default: address = (cur_low - PCPA_PAGE_BYTES) & ~32'(PCPA_PAGE_BYTES - 1);
            endcase
         end
         send_item(action, CPU_IN_W'($urandom_range(0, PCPA_CPUS - 1)), address);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(ACTION_ALLOC, 3'd0, 32'hFFFF_FFFF);
      send_item(ACTION_FREE,  3'd7, 32'h0000_0000);

      write_config(32'h0000_1800, 32'h0010_0000);
      send_item(ACTION_FREE,  3'd0, 32'h0000_2000);
      send_item(ACTION_FREE,  3'd1, 32'h0000_1000);
      send_item(ACTION_FREE,  3'd0, 32'h0000_2004);
      send_item(ACTION_FREE,  3'd0, 32'h0010_0000);
      send_item(ACTION_FREE,  3'd3, 32'h000F_F000);
      send_item(ACTION_FREE,  3'd0, 32'h0000_3000);
      repeat (4) send_item(ACTION_ALLOC, 3'd0, 32'h0);
      send_item(ACTION_FREE,  3'd1, 32'h0000_5000);
      send_item(ACTION_ALLOC, 3'd7, 32'h0);
      repeat (2) send_item(ACTION_FREE, 3'd2, 32'h0000_6000);
      repeat (2) send_item(ACTION_ALLOC, 3'd2, 32'h0);
      send_item(ACTION_FREE,  3'd4, 32'h0000_7000);

      write_config(32'h0000_0000, 32'hFFFF_FFFF);
      send_item(ACTION_ALLOC, 3'd4, 32'h0);
      send_item(ACTION_FREE,  3'd6, 32'h0800_0000);
      send_item(ACTION_FREE,  3'd6, 32'h07FF_F000);
      send_item(ACTION_FREE,  3'd6, 32'hFFFF_F000);
      send_item(ACTION_FREE,  3'd5, 32'h0000_3000);

      write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACTION_FREE,  3'd5, 32'hFFFF_F000);
      send_item(ACTION_ALLOC, 3'd5, 32'h0);
      send_item(ACTION_ALLOC, 3'd6, 32'h0);
      send_item(ACTION_ALLOC, 3'd0, 32'h0);

      lo = $urandom & 32'h3FFF_FFFF;
      write_config(lo, lo + $urandom_range(16, 600) * PCPA_PAGE_BYTES);
      run_random(220, 45);
      write_config(32'h0000_0000, 32'hFFFF_FFFF);
      run_random(200, 35);
      write_config(32'hF000_0001, 32'hFFFF_FFFF);
      run_random(200, 55);
      lo = $urandom;
      hi = $urandom;
      if (hi < lo) write_config(hi, lo);
      else write_config(lo, hi);
      run_random(230, 50);

      wait_idle();
      end_of_run <= 1'b1;
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
